// ----- rtl/hit_direction_angle_binner_assert.svh -----
// Assertion macros shared by the angle binner RTL.
`ifndef HIT_DIRECTION_ANGLE_BINNER_ASSERT_SVH
`define HIT_DIRECTION_ANGLE_BINNER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while rst_n is low
`define HDAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdab assertion failed");
// next-cycle implication
`define HDAB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdab assertion failed");
`else
`define HDAB_ASSERT_IMP(lbl, ante, cons)
`define HDAB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/hdab_pkg.sv -----
// Shared types, constants and the arctangent table of the angle binner.
`timescale 1ns / 1ps
package hdab_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int THETA_BINS_DEF    = 100;
  localparam int PHI_BINS_DEF      = 720;

  localparam int THETA_LO_DEG = 0;
  localparam int THETA_HI_DEG = 50;
  localparam int PHI_LO_DEG   = -360;
  localparam int PHI_HI_DEG   = 360;
  localparam int ANG_ONE      = 256;
  localparam int ANG_MAX      = 46080;

  // CORDIC datapath: coordinates are prescaled to a fixed 60-bit point
  localparam int CW           = 64;
  localparam int ACC_W        = 32;
  localparam int PRESCALE_TOP = 60;
  localparam int RIGHT_ANGLE  = 90 * 65536;
  localparam int ANG_W        = 17;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int TARGET_Z_FLOOR_RST = -512;
  localparam int RIGHT_X_FLOOR_RST  = 80;
  localparam int LEFT_X_CEILING_RST = 0;
  localparam int HIT_Y_FLOOR_RST    = 0;
  localparam int HIT_Z_FLOOR_RST    = 1600;

  typedef enum logic [2:0] {
    REG_TARGET_Z_FLOOR = 3'd0,
    REG_RIGHT_X_FLOOR  = 3'd1,
    REG_LEFT_X_CEILING = 3'd2,
    REG_HIT_Y_FLOOR    = 3'd3,
    REG_HIT_Z_FLOOR    = 3'd4
  } reg_idx_t;

  // control that rides alongside the data through every stage
  typedef struct packed {
    logic [1:0] det;
    logic       pass;
    logic       ok;
    logic       vert;
  } ctl_t;

  // round(atan(2^-i) * 65536), degrees
  function automatic logic signed [ACC_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/hdab_front.sv -----
// Front end: acceptance cuts, difference vector, squares and their sum.
`timescale 1ns / 1ps
module hdab_front #(
  parameter int CB = hdab_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_detector,
  input  logic signed [CB-1:0] in_target_x,
  input  logic signed [CB-1:0] in_target_y,
  input  logic signed [CB-1:0] in_target_z,
  input  logic signed [CB-1:0] in_hit_x,
  input  logic signed [CB-1:0] in_hit_y,
  input  logic signed [CB-1:0] in_hit_z,
  input  logic signed [CB-1:0] tz_floor,
  input  logic signed [CB-1:0] rx_floor,
  input  logic signed [CB-1:0] lx_ceil,
  input  logic signed [CB-1:0] hy_floor,
  input  logic signed [CB-1:0] hz_floor,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hdab_pkg::ctl_t       out_ctl,
  output logic signed [CB:0]   out_dx,
  output logic signed [CB:0]   out_dy,
  output logic signed [CB:0]   out_dz,
  output logic [2*CB+1:0]      out_sq
);

  localparam int R = CB + 1;
  localparam int N = 3;

  logic [N-1:0] v_r, v_nxt, rdy;

  hdab_pkg::ctl_t        c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic signed [R-1:0]   dx0_r, dy0_r, dz0_r, dx0_nxt, dy0_nxt, dz0_nxt;
  logic signed [R-1:0]   dx1_r, dy1_r, dz1_r, dx2_r, dy2_r, dz2_r;
  logic [2*R-1:0]        sx1_r, sy1_r, sx1_nxt, sy1_nxt, sq2_r, sq2_nxt;
  logic [R-1:0]          ax, ay;

  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < N; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  // stage 0: cuts and differences; dx is mirrored on the left side
  always_comb begin
    c0_nxt      = '0;
    c0_nxt.det  = in_detector;
    c0_nxt.pass = (in_target_z > tz_floor) && (in_hit_y > hy_floor) &&
                  (in_hit_z > hz_floor) &&
                  (in_detector[1] ? (in_hit_x < lx_ceil) : (in_hit_x > rx_floor));
    dx0_nxt = in_detector[1] ? (R'(in_target_x) - R'(in_hit_x))
                             : (R'(in_hit_x) - R'(in_target_x));
    dy0_nxt = R'(in_hit_y) - R'(in_target_y);
    dz0_nxt = R'(in_hit_z) - R'(in_target_z);
  end

  // stage 1: squares
  always_comb begin
    ax      = dx0_r[R-1] ? R'(-dx0_r) : R'(dx0_r);
    ay      = dy0_r[R-1] ? R'(-dy0_r) : R'(dy0_r);
    sx1_nxt = {{R{1'b0}}, ax} * {{R{1'b0}}, ax};
    sy1_nxt = {{R{1'b0}}, ay} * {{R{1'b0}}, ay};
    c1_nxt      = c0_r;
    c1_nxt.vert = (dx0_r == '0) && (dy0_r == '0);
    c1_nxt.ok   = c0_r.pass && ((dx0_r != '0) || (dy0_r != '0) || (dz0_r != '0));
  end

  // stage 2: sum of squares
  always_comb begin
    sq2_nxt = sx1_r + sy1_r;
    c2_nxt  = c1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0_r  <= c0_nxt;
      dx0_r <= dx0_nxt;
      dy0_r <= dy0_nxt;
      dz0_r <= dz0_nxt;
    end
    if (rdy[1]) begin
      c1_r  <= c1_nxt;
      sx1_r <= sx1_nxt;
      sy1_r <= sy1_nxt;
      dx1_r <= dx0_r;
      dy1_r <= dy0_r;
      dz1_r <= dz0_r;
    end
    if (rdy[2]) begin
      c2_r  <= c2_nxt;
      sq2_r <= sq2_nxt;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      dz2_r <= dz1_r;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_ctl   = c2_r;
  assign out_dx    = dx2_r;
  assign out_dy    = dy2_r;
  assign out_dz    = dz2_r;
  assign out_sq    = sq2_r;

endmodule

// ----- rtl/hdab_isqrt.sv -----
// Pipelined restoring square root, one root bit per stage.
`timescale 1ns / 1ps
module hdab_isqrt #(
  parameter int CB = hdab_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hdab_pkg::ctl_t      in_ctl,
  input  logic signed [CB:0]  in_dx,
  input  logic signed [CB:0]  in_dy,
  input  logic signed [CB:0]  in_dz,
  input  logic [2*CB+1:0]     in_sq,
  output logic                out_valid,
  input  logic                out_ready,
  output hdab_pkg::ctl_t      out_ctl,
  output logic signed [CB:0]  out_dx,
  output logic signed [CB:0]  out_dy,
  output logic signed [CB:0]  out_dz,
  output logic [CB:0]         out_rho
);

  localparam int R = CB + 1;
  localparam int N = R;
  localparam int RW = R + 2;

  logic [N-1:0] v_r, v_nxt, rdy;

  hdab_pkg::ctl_t      c_r   [N];
  logic signed [R-1:0] dx_r  [N];
  logic signed [R-1:0] dy_r  [N];
  logic signed [R-1:0] dz_r  [N];
  logic [2*R-1:0]      rad_r [N];
  logic [RW-1:0]       rem_r [N];
  logic [R-1:0]        root_r[N];
  logic [RW-1:0]       rem_nxt [N];
  logic [R-1:0]        root_nxt[N];

  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < N; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  // stage j brings down radicand pair R-1-j
  always_comb begin
    logic [RW-1:0]  rem_p, rem_s, trial;
    logic [R-1:0]   root_p;
    logic [2*R-1:0] rad_p;
    logic [1:0]     pair;
    logic           ge;
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = in_sq;
      end else begin
        rem_p  = rem_r[j-1];
        root_p = root_r[j-1];
        rad_p  = rad_r[j-1];
      end
      pair  = rad_p[2*(R-1-j) +: 2];
      rem_s = {rem_p[RW-3:0], pair};
      trial = {root_p, 2'b01};
      ge    = (rem_s >= trial);
      rem_nxt[j]  = ge ? (rem_s - trial) : rem_s;
      root_nxt[j] = {root_p[R-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      if (rdy[j]) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        if (j == 0) begin
          c_r[j]   <= in_ctl;
          dx_r[j]  <= in_dx;
          dy_r[j]  <= in_dy;
          dz_r[j]  <= in_dz;
          rad_r[j] <= in_sq;
        end else begin
          c_r[j]   <= c_r[j-1];
          dx_r[j]  <= dx_r[j-1];
          dy_r[j]  <= dy_r[j-1];
          dz_r[j]  <= dz_r[j-1];
          rad_r[j] <= rad_r[j-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_ctl   = c_r[N-1];
  assign out_dx    = dx_r[N-1];
  assign out_dy    = dy_r[N-1];
  assign out_dz    = dz_r[N-1];
  assign out_rho   = root_r[N-1];

endmodule

// ----- rtl/hdab_cordic.sv -----
// Two-lane unrolled CORDIC vectoring pipeline: theta from (dz, rho), phi from (dx, dy).
`timescale 1ns / 1ps
module hdab_cordic #(
  parameter int CB = hdab_pkg::COORD_BITS_DEF,
  parameter int NS = hdab_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  hdab_pkg::ctl_t                         in_ctl,
  input  logic signed [CB:0]                     in_dx,
  input  logic signed [CB:0]                     in_dy,
  input  logic signed [CB:0]                     in_dz,
  input  logic [CB:0]                            in_rho,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output hdab_pkg::ctl_t                         out_ctl,
  output logic signed [hdab_pkg::ACC_W-1:0]      out_th_acc,
  output logic signed [hdab_pkg::ACC_W-1:0]      out_ph_acc
);

  localparam int CW = hdab_pkg::CW;
  localparam int AW = hdab_pkg::ACC_W;
  localparam int PS = hdab_pkg::PRESCALE_TOP - CB;
  localparam int N  = NS + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] a;
  } vec_t;

  // left half-plane is folded by a quarter turn first
  function automatic vec_t pre_rot(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y);
    vec_t v;
    v.x = x;
    v.y = y;
    v.a = '0;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        v.x = y;
        v.y = -x;
        v.a = AW'(hdab_pkg::RIGHT_ANGLE);
      end else begin
        v.x = -y;
        v.y = x;
        v.a = -AW'(hdab_pkg::RIGHT_ANGLE);
      end
    end
    return v;
  endfunction

  function automatic vec_t rot_step(input vec_t v, input int i);
    vec_t                 o;
    logic signed [CW-1:0] xs, ys;
    xs = v.x >>> i;
    ys = v.y >>> i;
    if (!v.y[CW-1]) begin
      o.x = v.x + ys;
      o.y = v.y - xs;
      o.a = v.a + hdab_pkg::atan_lut(5'(i));
    end else begin
      o.x = v.x - ys;
      o.y = v.y + xs;
      o.a = v.a - hdab_pkg::atan_lut(5'(i));
    end
    return o;
  endfunction

  logic [N-1:0] v_r, v_nxt, rdy;

  hdab_pkg::ctl_t c_r   [N];
  vec_t           th_r  [N];
  vec_t           ph_r  [N];
  vec_t           th_nxt[N];
  vec_t           ph_nxt[N];

  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < N; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_comb begin
    logic signed [CW-1:0] zx, ry, px, py;
    zx = CW'(in_dz) <<< PS;
    ry = $signed(CW'(in_rho)) <<< PS;
    px = CW'(in_dx) <<< PS;
    py = CW'(in_dy) <<< PS;
    th_nxt[0] = pre_rot(zx, ry);
    ph_nxt[0] = pre_rot(px, py);
    for (int s = 1; s < N; s++) begin
      th_nxt[s] = rot_step(th_r[s-1], s - 1);
      ph_nxt[s] = rot_step(ph_r[s-1], s - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (rdy[s]) begin
        th_r[s] <= th_nxt[s];
        ph_r[s] <= ph_nxt[s];
        c_r[s]  <= (s == 0) ? in_ctl : c_r[s-1];
      end
    end
  end

  assign in_ready   = rdy[0];
  assign out_valid  = v_r[N-1];
  assign out_ctl    = c_r[N-1];
  assign out_th_acc = th_r[N-1].a;
  assign out_ph_acc = ph_r[N-1].a;

endmodule

// ----- rtl/hdab_bin.sv -----
// Angle rounding, clamping and histogram bin numbers; holds the output register.
`timescale 1ns / 1ps
module hdab_bin #(
  parameter int THETA_BINS = hdab_pkg::THETA_BINS_DEF,
  parameter int PHI_BINS   = hdab_pkg::PHI_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hdab_pkg::ctl_t                    in_ctl,
  input  logic signed [hdab_pkg::ACC_W-1:0] in_th_acc,
  input  logic signed [hdab_pkg::ACC_W-1:0] in_ph_acc,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accepted,
  output logic [1:0]                        out_detector_out,
  output logic [15:0]                       out_theta_deg,
  output logic signed [16:0]                out_phi_deg,
  output logic [6:0]                        out_theta_bin,
  output logic [9:0]                        out_phi_bin
);

  localparam int AW = hdab_pkg::ACC_W;
  localparam int GW = hdab_pkg::ANG_W;
  localparam int N  = 3;

  localparam int TH_A    = hdab_pkg::THETA_LO_DEG * hdab_pkg::ANG_ONE;
  localparam int TH_B    = hdab_pkg::THETA_HI_DEG * hdab_pkg::ANG_ONE;
  localparam int TH_SPAN = TH_B - TH_A;
  localparam int TH_NK   = $clog2(TH_SPAN * THETA_BINS);
  localparam int TH_S    = TH_NK + $clog2(TH_SPAN);
  localparam longint TH_M64 = ((longint'(1) << TH_S) + TH_SPAN - 1) / TH_SPAN;
  localparam logic [TH_NK+1:0] TH_M = (TH_NK+2)'(TH_M64);

  localparam int PH_A    = hdab_pkg::PHI_LO_DEG * hdab_pkg::ANG_ONE;
  localparam int PH_B    = hdab_pkg::PHI_HI_DEG * hdab_pkg::ANG_ONE;
  localparam int PH_SPAN = PH_B - PH_A;
  localparam int PH_NK   = $clog2(PH_SPAN * PHI_BINS);
  localparam int PH_S    = PH_NK + $clog2(PH_SPAN);
  localparam longint PH_M64 = ((longint'(1) << PH_S) + PH_SPAN - 1) / PH_SPAN;
  localparam logic [PH_NK+1:0] PH_M = (PH_NK+2)'(PH_M64);

  logic [N-1:0] v_r, v_nxt, rdy;

  hdab_pkg::ctl_t       c0_r, c1_r;
  logic signed [GW-1:0] th0_r, ph0_r, th0_nxt, ph0_nxt, th1_r, ph1_r;
  logic [TH_NK-1:0]     thp1_r, thp1_nxt;
  logic [PH_NK-1:0]     php1_r, php1_nxt;
  logic                 thu1_r, tho1_r, phu1_r, pho1_r;
  logic                 thu1_nxt, tho1_nxt, phu1_nxt, pho1_nxt;

  logic                 acc2_r;
  logic [1:0]           det2_r;
  logic [15:0]          thd2_r, thd2_nxt;
  logic signed [GW-1:0] phd2_r, phd2_nxt;
  logic [6:0]           thb2_r, thb2_nxt;
  logic [9:0]           phb2_r, phb2_nxt;

  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < N; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  // stage 0: round to 8 fraction bits and clamp
  always_comb begin
    logic signed [AW-1:0] rt, rp;
    rt = (in_th_acc + AW'(128)) >>> 8;
    rp = (in_ph_acc + AW'(128)) >>> 8;
    if (rt > hdab_pkg::ANG_MAX) rt = AW'(hdab_pkg::ANG_MAX);
    if (rt < 0) rt = '0;
    if (rp > hdab_pkg::ANG_MAX) rp = AW'(hdab_pkg::ANG_MAX);
    if (rp < -hdab_pkg::ANG_MAX) rp = -AW'(hdab_pkg::ANG_MAX);
    // straight up or down: azimuth is defined as zero
    if (in_ctl.vert) rp = '0;
    th0_nxt = GW'(rt);
    ph0_nxt = GW'(rp);
  end

  // stage 1: range checks and offset times bin count
  always_comb begin
    int tv, pv;
    tv = int'(th0_r);
    pv = int'(ph0_r);
    thu1_nxt = tv < TH_A;
    tho1_nxt = tv >= TH_B;
    phu1_nxt = pv < PH_A;
    pho1_nxt = pv >= PH_B;
    thp1_nxt = TH_NK'((tv - TH_A) * THETA_BINS);
    php1_nxt = PH_NK'((pv - PH_A) * PHI_BINS);
  end

  // stage 2: divide by the span through its reciprocal, then the result register
  always_comb begin
    logic [2*TH_NK+1:0] tq;
    logic [2*PH_NK+1:0] pq;
    logic [15:0]        tb, pb;
    tq = {{(TH_NK+2){1'b0}}, thp1_r} * {{TH_NK{1'b0}}, TH_M};
    pq = {{(PH_NK+2){1'b0}}, php1_r} * {{PH_NK{1'b0}}, PH_M};
    tb = thu1_r ? 16'd0 : (tho1_r ? 16'(THETA_BINS + 1) : 16'(tq >> TH_S) + 16'd1);
    pb = phu1_r ? 16'd0 : (pho1_r ? 16'(PHI_BINS + 1) : 16'(pq >> PH_S) + 16'd1);
    thd2_nxt = c1_r.ok ? 16'(th1_r) : '0;
    phd2_nxt = c1_r.ok ? ph1_r : '0;
    thb2_nxt = c1_r.ok ? 7'(tb) : '0;
    phb2_nxt = c1_r.ok ? 10'(pb) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0_r  <= in_ctl;
      th0_r <= th0_nxt;
      ph0_r <= ph0_nxt;
    end
    if (rdy[1]) begin
      c1_r   <= c0_r;
      th1_r  <= th0_r;
      ph1_r  <= ph0_r;
      thp1_r <= thp1_nxt;
      php1_r <= php1_nxt;
      thu1_r <= thu1_nxt;
      tho1_r <= tho1_nxt;
      phu1_r <= phu1_nxt;
      pho1_r <= pho1_nxt;
    end
    if (rdy[2]) begin
      acc2_r <= c1_r.ok;
      det2_r <= c1_r.det;
      thd2_r <= thd2_nxt;
      phd2_r <= phd2_nxt;
      thb2_r <= thb2_nxt;
      phb2_r <= phb2_nxt;
    end
  end

  assign in_ready         = rdy[0];
  assign out_valid        = v_r[N-1];
  assign out_accepted     = acc2_r;
  assign out_detector_out = det2_r;
  assign out_theta_deg    = thd2_r;
  assign out_phi_deg      = phd2_r;
  assign out_theta_bin    = thb2_r;
  assign out_phi_bin      = phb2_r;

endmodule

// ----- rtl/hit_direction_angle_binner.sv -----
// Top level of the hit direction angle binner: register file and pipeline chain.
//
// Input channel (in_valid/in_ready): one item is a target point, a detector
// hit and a detector index. Output channel (out_valid/out_ready): exactly one
// result per item, in order: accepted flag, detector, theta and phi in degrees
// with 8 fraction bits, and their histogram bins. Rejected items come out with
// every field zero but the detector.
// The chain holds three front stages (cuts, squares, sum), one stage per root
// bit of the square root, a prerotation plus one stage per CORDIC iteration,
// and three stages of rounding and binning. One item is taken every cycle
// while the output is not stalled.
// Every stage has its own valid bit; a stalled receiver holds the output
// register and stages fill up behind it, so items keep entering until the
// pipeline is full. Reset clears all valid bits and loads the cut registers
// with their defaults. Cut registers sit on the APB port at 4*index; write
// them only while no item is in flight, as the block does not enforce it.
`timescale 1ns / 1ps
`include "hit_direction_angle_binner_assert.svh"
module hit_direction_angle_binner #(
  parameter int COORD_BITS    = hdab_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = hdab_pkg::CORDIC_STAGES_DEF,
  parameter int THETA_BINS    = hdab_pkg::THETA_BINS_DEF,
  parameter int PHI_BINS      = hdab_pkg::PHI_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_detector,
  input  logic signed [COORD_BITS-1:0]  in_target_x,
  input  logic signed [COORD_BITS-1:0]  in_target_y,
  input  logic signed [COORD_BITS-1:0]  in_target_z,
  input  logic signed [COORD_BITS-1:0]  in_hit_x,
  input  logic signed [COORD_BITS-1:0]  in_hit_y,
  input  logic signed [COORD_BITS-1:0]  in_hit_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [1:0]                    out_detector_out,
  output logic [15:0]                   out_theta_deg,
  output logic signed [16:0]            out_phi_deg,
  output logic [6:0]                    out_theta_bin,
  output logic [9:0]                    out_phi_bin,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdab_pkg::ADDR_W-1:0]   paddr,
  input  logic [hdab_pkg::DATA_W-1:0]   pwdata,
  output logic [hdab_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] tz_floor_r, rx_floor_r, lx_ceil_r, hy_floor_r, hz_floor_r;
  hdab_pkg::reg_idx_t   ridx;

  assign ridx   = hdab_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_floor_r <= CB'(hdab_pkg::TARGET_Z_FLOOR_RST);
      rx_floor_r <= CB'(hdab_pkg::RIGHT_X_FLOOR_RST);
      lx_ceil_r  <= CB'(hdab_pkg::LEFT_X_CEILING_RST);
      hy_floor_r <= CB'(hdab_pkg::HIT_Y_FLOOR_RST);
      hz_floor_r <= CB'(hdab_pkg::HIT_Z_FLOOR_RST);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        hdab_pkg::REG_TARGET_Z_FLOOR: tz_floor_r <= pwdata[CB-1:0];
        hdab_pkg::REG_RIGHT_X_FLOOR:  rx_floor_r <= pwdata[CB-1:0];
        hdab_pkg::REG_LEFT_X_CEILING: lx_ceil_r  <= pwdata[CB-1:0];
        hdab_pkg::REG_HIT_Y_FLOOR:    hy_floor_r <= pwdata[CB-1:0];
        hdab_pkg::REG_HIT_Z_FLOOR:    hz_floor_r <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      hdab_pkg::REG_TARGET_Z_FLOOR: prdata = hdab_pkg::DATA_W'(tz_floor_r);
      hdab_pkg::REG_RIGHT_X_FLOOR:  prdata = hdab_pkg::DATA_W'(rx_floor_r);
      hdab_pkg::REG_LEFT_X_CEILING: prdata = hdab_pkg::DATA_W'(lx_ceil_r);
      hdab_pkg::REG_HIT_Y_FLOOR:    prdata = hdab_pkg::DATA_W'(hy_floor_r);
      hdab_pkg::REG_HIT_Z_FLOOR:    prdata = hdab_pkg::DATA_W'(hz_floor_r);
      default:                      prdata = '0;
    endcase
  end

  logic              f_valid, f_ready, s_valid, s_ready, c_valid, c_ready;
  hdab_pkg::ctl_t    f_ctl, s_ctl, c_ctl;
  logic signed [CB:0] f_dx, f_dy, f_dz, s_dx, s_dy, s_dz;
  logic [2*CB+1:0]   f_sq;
  logic [CB:0]       s_rho;
  logic signed [hdab_pkg::ACC_W-1:0] c_th, c_ph;

  hdab_front #(.CB(CB)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_detector(in_detector),
    .in_target_x(in_target_x), .in_target_y(in_target_y), .in_target_z(in_target_z),
    .in_hit_x(in_hit_x), .in_hit_y(in_hit_y), .in_hit_z(in_hit_z),
    .tz_floor(tz_floor_r), .rx_floor(rx_floor_r), .lx_ceil(lx_ceil_r),
    .hy_floor(hy_floor_r), .hz_floor(hz_floor_r),
    .out_valid(f_valid), .out_ready(f_ready), .out_ctl(f_ctl),
    .out_dx(f_dx), .out_dy(f_dy), .out_dz(f_dz), .out_sq(f_sq)
  );

  hdab_isqrt #(.CB(CB)) u_isqrt (
    .clk(clk), .rst_n(rst_n),
    .in_valid(f_valid), .in_ready(f_ready), .in_ctl(f_ctl),
    .in_dx(f_dx), .in_dy(f_dy), .in_dz(f_dz), .in_sq(f_sq),
    .out_valid(s_valid), .out_ready(s_ready), .out_ctl(s_ctl),
    .out_dx(s_dx), .out_dy(s_dy), .out_dz(s_dz), .out_rho(s_rho)
  );

  hdab_cordic #(.CB(CB), .NS(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s_valid), .in_ready(s_ready), .in_ctl(s_ctl),
    .in_dx(s_dx), .in_dy(s_dy), .in_dz(s_dz), .in_rho(s_rho),
    .out_valid(c_valid), .out_ready(c_ready), .out_ctl(c_ctl),
    .out_th_acc(c_th), .out_ph_acc(c_ph)
  );

  hdab_bin #(.THETA_BINS(THETA_BINS), .PHI_BINS(PHI_BINS)) u_bin (
    .clk(clk), .rst_n(rst_n),
    .in_valid(c_valid), .in_ready(c_ready), .in_ctl(c_ctl),
    .in_th_acc(c_th), .in_ph_acc(c_ph),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_detector_out(out_detector_out),
    .out_theta_deg(out_theta_deg), .out_phi_deg(out_phi_deg),
    .out_theta_bin(out_theta_bin), .out_phi_bin(out_phi_bin)
  );

  // a rejected item carries nothing but its detector
  `HDAB_ASSERT_IMP(a_reject_zero, out_valid && !out_accepted, out_theta_deg == '0 && out_phi_deg == '0 && out_theta_bin == '0 && out_phi_bin == '0)
  `HDAB_ASSERT_IMP(a_theta_range, out_valid, out_theta_deg <= 16'(hdab_pkg::ANG_MAX))
  // an empty output register means the whole chain can move
  `HDAB_ASSERT_IMP(a_idle_ready, !out_valid, in_ready)
  `HDAB_ASSERT_NXT(a_cfg_write, psel && penable && pwrite && ridx == hdab_pkg::REG_HIT_Z_FLOOR, hz_floor_r == $past(pwdata[CB-1:0]))

endmodule
